// ===== rtl/core/mau_pkg.sv =====
// Shared types and constants for the modular arithmetic unit.
`default_nettype none

package mau_pkg;

   localparam int FIELD_WIDTH    = 31;
   localparam int FUNC_WIDTH     = 3;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_LSB  = 2;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - CSR_INDEX_LSB;

   localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 31'd1000000007;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MODULUS = 1'd0;

   localparam logic [FUNC_WIDTH-1:0] FUNC_ADD = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SUB = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_NEG = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_MUL = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_DIV = 3'd4;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0]  func;
      logic [FIELD_WIDTH-1:0] operand_a;
      logic [FIELD_WIDTH-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] result;
      logic                   error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_DISPATCH,
      ST_EU_CHECK,
      ST_EU_ALIGN,
      ST_EU_SUB,
      ST_INV_NORM,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/mau_csr.sv =====
// APB-style configuration register block holding the modulus.
`default_nettype none

module mau_csr #(
   parameter int VALUE_WIDTH = 31
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mau_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [mau_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [mau_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                    csr_pready,
   output logic      [VALUE_WIDTH-1:0]             modulus
);
   import mau_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] MOD_RST = VALUE_WIDTH'(MODULUS_RESET);

   logic [VALUE_WIDTH-1:0]     modulus_ff;
   logic [VALUE_WIDTH-1:0]     modulus_in;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic                       write_beat;

   assign index      = csr_paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB];
   assign write_beat = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      modulus_in = modulus_ff;
      if (write_beat && (index == REG_MODULUS)) begin
         modulus_in = csr_pwdata[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_RST;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (index == REG_MODULUS) ? CSR_DATA_WIDTH'(modulus_ff) : '0;
   assign modulus    = modulus_ff;

endmodule

`default_nettype wire

// ===== rtl/core/modular_arithmetic_unit_core.sv =====
// Top level of the bit-serial modular arithmetic unit.
//
//   port group | direction | handshake        | beat contents
//   req_*      | in        | valid / ready    | func, operand_a, operand_b
//   rsp_*      | out       | valid / ready    | result, error
//   csr_*      | in / out  | APB, pready = 1  | modulus at byte address 0
//
// One item at a time; W = VALUE_WIDTH. Operand reduction shifts in one bit per
// cycle; add, subtract and negate then finish in the dispatch state, multiply
// takes one double and one add step per multiplier bit, and divide first runs the
// Euclid loop (align the divisor, then subtract one quotient bit at a time in each
// round) to form the inverse of b, which then goes through the same multiply.
// Reset clears the sequencer and the result valid; the modulus returns to its
// reset value. A finished result waits in the output register; the next request
// is taken meanwhile and stalls in its last state only until that beat leaves.
`default_nettype none

module modular_arithmetic_unit_core #(
   parameter int VALUE_WIDTH = 31
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire mau_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output mau_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mau_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [mau_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [mau_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                    csr_pready
);
   import mau_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int TW = VALUE_WIDTH + 2;
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_WIDTH - 1);

   function automatic logic [W-1:0] fold(input logic [W:0] x, input logic [W-1:0] m);
      logic [W:0] diff;
      diff = x - {1'b0, m};
      return (x >= {1'b0, m}) ? diff[W-1:0] : x[W-1:0];
   endfunction

   logic [W-1:0] m;

   state_type              state_ff,    state_in;
   logic [FUNC_WIDTH-1:0]  func_ff,     func_in;
   logic [W-1:0]           a_sh_ff,     a_sh_in;
   logic [W-1:0]           b_sh_ff,     b_sh_in;
   logic [W-1:0]           a_ff,        a_in;
   logic [W-1:0]           b_ff,        b_in;
   logic [W-1:0]           r0_ff,       r0_in;
   logic [W-1:0]           r1_ff,       r1_in;
   logic [W-1:0]           d_ff,        d_in;
   logic signed [TW-1:0]   t0_ff,       t0_in;
   logic signed [TW-1:0]   t1_ff,       t1_in;
   logic signed [TW-1:0]   td_ff,       td_in;
   logic [W-1:0]           acc_ff,      acc_in;
   logic [W-1:0]           mpl_ff,      mpl_in;
   logic [CW-1:0]          cnt_ff,      cnt_in;
   logic                   phase_ff,    phase_in;
   logic [W-1:0]           res_ff,      res_in;
   logic                   err_ff,      err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff,      rsp_in;

   logic [W-1:0]         red_a;
   logic [W-1:0]         red_b;
   logic [W-1:0]         add_v;
   logic [W:0]           sub_w;
   logic [W-1:0]         sub_v;
   logic [W-1:0]         neg_v;
   logic [W-1:0]         dbl_v;
   logic [W-1:0]         accadd_v;
   logic [W-1:0]         mul_v;
   logic                 eu_fit;
   logic                 eu_ge;
   logic [W-1:0]         eu_rem;
   logic signed [TW-1:0] eu_t;
   logic signed [TW-1:0] m_s;
   logic                 cnt_zero;

   mau_csr #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .modulus    (m)
   );

   assign red_a    = fold({a_ff, a_sh_ff[W-1]}, m);
   assign red_b    = fold({b_ff, b_sh_ff[W-1]}, m);
   assign add_v    = fold({1'b0, a_ff} + {1'b0, b_ff}, m);
   assign sub_w    = {1'b0, a_ff} + {1'b0, m} - {1'b0, b_ff};
   assign sub_v    = (a_ff >= b_ff) ? (a_ff - b_ff) : sub_w[W-1:0];
   assign neg_v    = (a_ff == '0) ? '0 : (m - a_ff);
   assign dbl_v    = fold({acc_ff, 1'b0}, m);
   assign accadd_v = fold({1'b0, acc_ff} + {1'b0, a_ff}, m);
   assign mul_v    = mpl_ff[W-1] ? accadd_v : acc_ff;
   assign eu_fit   = {d_ff, 1'b0} <= {1'b0, r0_ff};
   assign eu_ge    = d_ff <= r0_ff;
   assign eu_rem   = eu_ge ? (r0_ff - d_ff) : r0_ff;
   assign eu_t     = eu_ge ? (t0_ff - td_ff) : t0_ff;
   assign m_s      = $signed({2'b00, m});
   assign cnt_zero = (cnt_ff == '0);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      a_sh_in      = a_sh_ff;
      b_sh_in      = b_sh_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      d_in         = d_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      td_in        = td_ff;
      acc_in       = acc_ff;
      mpl_in       = mpl_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = req_data.func;
               a_sh_in = req_data.operand_a[W-1:0];
               b_sh_in = req_data.operand_b[W-1:0];
               a_in    = '0;
               b_in    = '0;
               cnt_in  = CNT_LAST;
               res_in  = '0;
               err_in  = 1'b0;
               if (m == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            a_in    = red_a;
            b_in    = red_b;
            a_sh_in = {a_sh_ff[W-2:0], 1'b0};
            b_sh_in = {b_sh_ff[W-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_zero) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (func_ff)
               FUNC_ADD: begin
                  res_in   = add_v;
                  state_in = ST_DONE;
               end
               FUNC_SUB: begin
                  res_in   = sub_v;
                  state_in = ST_DONE;
               end
               FUNC_NEG: begin
                  res_in   = neg_v;
                  state_in = ST_DONE;
               end
               FUNC_MUL: begin
                  acc_in   = '0;
                  mpl_in   = b_ff;
                  cnt_in   = CNT_LAST;
                  phase_in = 1'b0;
                  state_in = ST_MUL;
               end
               FUNC_DIV: begin
                  r0_in    = m;
                  r1_in    = b_ff;
                  t0_in    = '0;
                  t1_in    = TW'(1);
                  state_in = ST_EU_CHECK;
               end
               default: begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_EU_CHECK: begin
            if (r1_ff == '0) begin
               state_in = ST_INV_NORM;
            end else begin
               d_in     = r1_ff;
               td_in    = t1_ff;
               cnt_in   = '0;
               state_in = ST_EU_ALIGN;
            end
         end
         ST_EU_ALIGN: begin
            if (eu_fit) begin
               d_in   = {d_ff[W-2:0], 1'b0};
               td_in  = td_ff <<< 1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_EU_SUB;
            end
         end
         ST_EU_SUB: begin
            if (cnt_zero) begin
               r0_in    = r1_ff;
               r1_in    = eu_rem;
               t0_in    = t1_ff;
               t1_in    = eu_t;
               state_in = ST_EU_CHECK;
            end else begin
               r0_in  = eu_rem;
               t0_in  = eu_t;
               d_in   = d_ff >> 1;
               td_in  = td_ff >>> 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_INV_NORM: begin
            priority if (r0_ff != W'(1)) begin
               res_in   = '0;
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else if (t0_ff < 0) begin
               t0_in = t0_ff + m_s;
            end else if (t0_ff >= m_s) begin
               t0_in = t0_ff - m_s;
            end else begin
               acc_in   = '0;
               mpl_in   = t0_ff[W-1:0];
               cnt_in   = CNT_LAST;
               phase_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (!phase_ff) begin
               acc_in   = dbl_v;
               phase_in = 1'b1;
            end else begin
               acc_in   = mul_v;
               mpl_in   = {mpl_ff[W-2:0], 1'b0};
               phase_in = 1'b0;
               cnt_in   = cnt_ff - 1'b1;
               if (cnt_zero) begin
                  res_in   = mul_v;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.result = FIELD_WIDTH'(res_ff);
               rsp_in.error  = err_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      a_sh_ff  <= a_sh_in;
      b_sh_ff  <= b_sh_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      d_ff     <= d_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      td_ff    <= td_in;
      acc_ff   <= acc_in;
      mpl_ff   <= mpl_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      res_ff   <= res_in;
      err_ff   <= err_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mau_checker.sv =====
// Port-level checker for the modular arithmetic unit, bound to the top level.
`default_nettype none

module mau_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire mau_pkg::rsp_type rsp_data
);
   import mau_pkg::*;

   // Hold a stalled result beat.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Drop the result valid out of reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.result == '0)
      else $error("error beat with non-zero result");

   // One item at a time: busy after each accepted request.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item in progress");

endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (.*);

`default_nettype wire
